// ----- design/fwrl_pkg.sv -----
// Shared types and constants for the fixed-window rate limiter.
// No dependencies; every other file of the block but fwrl_ram depends on this package.
package fwrl_pkg;

  localparam int CLASS_COUNT = 5;
  localparam int CMD_W       = 2;
  localparam int USER_W      = 8;
  localparam int CLASS_W     = 3;
  localparam int LIMIT_W     = 32;
  localparam int PERIOD_W    = 2;
  localparam int PERIODS_W   = CLASS_COUNT * PERIOD_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int RESULT_W    = 32;

  // Window period codes.
  localparam logic [PERIOD_W-1:0] MINUTE = 2'd2;
  localparam logic [PERIOD_W-1:0] HOUR   = 2'd3;

  // Register indexes: the five default limits sit below the period register.
  localparam logic [CFG_INDEX_W-1:0] REG_PERIODS = 3'd5;

  // Reset values: limit one, minute for reads and writes, hour for the rest.
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 32'd1;
  localparam logic [PERIODS_W-1:0] PERIODS_RESET = {HOUR, HOUR, HOUR, MINUTE, MINUTE};

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST  = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_SET      = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REQ,
    ST_TICK,
    ST_TICK_END
  } fsm_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [USER_W-1:0]   user_id;
    logic [CLASS_W-1:0]  op_class;
    logic [LIMIT_W-1:0]  limit_value;
    logic [PERIOD_W-1:0] window_period;
  } item_t;

  typedef struct packed {
    logic                accepted;
    logic [RESULT_W-1:0] request_count;
    logic                default_installed;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // input channel ready
    logic load;        // capture the incoming transaction
    logic rd_item;     // read the table entry addressed by the input
    logic set_wr;      // write a set command into the table
    logic req_commit;  // update the entry and load the result register
    logic clr_wr;      // clearing pass: invalidate the entry at the sweep counter
    logic swp_rd;      // tick sweep: read the entry at the sweep counter
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_code_t in_cmd;
    logic      in_limited;
    logic      in_period_nz;
    logic      cnt_last;
    logic      out_busy;
  } dp_status_t;

endpackage

// ----- design/fwrl_item_if.sv -----
// Input channel of the rate limiter: valid, ready and one command item.
// Depends on fwrl_pkg for the payload type.
interface fwrl_item_if;
  logic           valid;
  logic           ready;
  fwrl_pkg::item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/fwrl_result_if.sv -----
// Result channel of the rate limiter: valid, ready and one request verdict.
// Depends on fwrl_pkg for the payload type.
interface fwrl_result_if;
  logic             valid;
  logic             ready;
  fwrl_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/fwrl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fwrl_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/fwrl_ctrl.sv -----
// Controller of the rate limiter: sequences clearing pass, requests, sets and ticks.
// Depends on fwrl_pkg for the state, command and status types.
module fwrl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  fwrl_pkg::dp_status_t   st,
  output fwrl_pkg::ctrl_cmd_t    cmd
);
  import fwrl_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          case (st.in_cmd)
            CMD_REQUEST: begin
              cmd.rd_item = st.in_limited;
              state_next  = ST_REQ;
            end
            CMD_TICK: begin
              if (st.in_period_nz) begin
                state_next = ST_TICK;
              end
            end
            CMD_SET: begin
              cmd.set_wr = st.in_limited;
            end
            default: begin
            end
          endcase
        end
      end
      ST_REQ: begin
        if (!st.out_busy) begin
          cmd.req_commit = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_TICK: begin
        cmd.swp_rd = 1'b1;
        if (st.cnt_last) begin
          state_next = ST_TICK_END;
        end
      end
      ST_TICK_END: begin
        // The last swept entry is written back in this cycle.
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- design/fwrl_datapath.sv -----
// Datapath of the rate limiter: default registers, entry table, sweep counter,
// count update and result register. Depends on fwrl_pkg and fwrl_ram.
module fwrl_datapath #(
  parameter int USER_COUNT = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fwrl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fwrl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fwrl_pkg::item_t                     item_payload,
  input  fwrl_pkg::ctrl_cmd_t                 cmd,
  output fwrl_pkg::dp_status_t                st,
  output logic                                result_valid,
  input  logic                                result_ready,
  output fwrl_pkg::result_t                   result_payload
);
  import fwrl_pkg::*;

  localparam int DEPTH   = CLASS_COUNT * USER_COUNT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LIM_LSB = COUNT_BITS;
  localparam int PER_LSB = COUNT_BITS + LIMIT_W;
  localparam int VLD_BIT = PER_LSB + PERIOD_W;
  localparam int WORD_W  = VLD_BIT + 1;
  localparam int CMP_W   = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic [LIMIT_W-1:0]    def_limit [CLASS_COUNT];
  logic [PERIODS_W-1:0]  def_periods;

  logic [ADDR_W-1:0]     cnt;
  logic                  wb_pend;
  logic [ADDR_W-1:0]     wb_addr;

  logic [CLASS_W-1:0]    item_cls;
  logic                  item_limited;
  logic [ADDR_W-1:0]     item_idx;
  logic [PERIOD_W-1:0]   tick_period;

  logic                  in_limited;
  logic [ADDR_W-1:0]     in_idx;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  logic                  rd_valid;
  logic [COUNT_BITS-1:0] base_cnt;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [LIMIT_W-1:0]    entry_lim;
  logic [PERIOD_W-1:0]   entry_per;
  logic                  under_limit;
  logic                  wb_hit;
  logic                  step;

  // Decode of the incoming transaction.
  assign in_limited = (item_payload.op_class < CLASS_W'(CLASS_COUNT)) &&
                      (32'(item_payload.user_id) < 32'(USER_COUNT));
  assign in_idx     = ADDR_W'(item_payload.op_class) * ADDR_W'(USER_COUNT) +
                      ADDR_W'(item_payload.user_id);

  assign step = cmd.clr_wr || cmd.swp_rd;

  assign st.in_cmd       = cmd_code_t'(item_payload.command);
  assign st.in_limited   = in_limited;
  assign st.in_period_nz = (item_payload.window_period != '0);
  assign st.cnt_last     = (cnt == ADDR_W'(DEPTH - 1));
  assign st.out_busy     = result_valid && !result_ready;

  // Default limits and periods.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        def_limit[c] <= LIMIT_RESET;
      end
      def_periods <= PERIODS_RESET;
    end else if (cfg_we) begin
      if (cfg_index < REG_PERIODS) begin
        def_limit[cfg_index] <= cfg_data[LIMIT_W-1:0];
      end else if (cfg_index == REG_PERIODS) begin
        def_periods <= cfg_data[PERIODS_W-1:0];
      end
    end
  end

  // Sweep counter and tick write-back flag; the counter returns to zero after each pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      wb_pend <= 1'b0;
    end else begin
      if (step) begin
        cnt <= st.cnt_last ? '0 : cnt + 1'b1;
      end
      wb_pend <= cmd.swp_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.swp_rd) begin
      wb_addr <= cnt;
    end
  end

  // Capture of the accepted transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cls     <= item_payload.op_class;
      item_limited <= in_limited;
      item_idx     <= in_idx;
      tick_period  <= item_payload.window_period;
    end
  end

  // Entry lookup: a missing entry takes its class defaults and a zero count.
  assign rd_valid    = ram_rdata[VLD_BIT];
  assign base_cnt    = rd_valid ? ram_rdata[COUNT_BITS-1:0] : '0;
  assign entry_lim   = rd_valid ? ram_rdata[LIM_LSB +: LIMIT_W] : def_limit[item_cls];
  assign entry_per   = rd_valid ? ram_rdata[PER_LSB +: PERIOD_W]
                                : def_periods[{item_cls, 1'b0} +: PERIOD_W];
  assign cnt_new     = (base_cnt == '1) ? base_cnt : base_cnt + COUNT_BITS'(1);
  assign under_limit = (CMP_W'(cnt_new) <= CMP_W'(entry_lim));

  // A swept entry has its count cleared when its period matches the tick.
  assign wb_hit = wb_pend && ram_rdata[VLD_BIT] &&
                  (ram_rdata[PER_LSB +: PERIOD_W] == tick_period);

  // Table write port: one source at a time.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (wb_hit) begin
      ram_we    = 1'b1;
      ram_waddr = wb_addr;
      ram_wdata = {ram_rdata[WORD_W-1:COUNT_BITS], COUNT_BITS'(0)};
    end else if (cmd.req_commit && item_limited) begin
      ram_we    = 1'b1;
      ram_waddr = item_idx;
      ram_wdata = {1'b1, entry_per, entry_lim, cnt_new};
    end else if (cmd.set_wr) begin
      ram_we    = 1'b1;
      ram_waddr = in_idx;
      ram_wdata = {1'b1, item_payload.window_period, item_payload.limit_value,
                   COUNT_BITS'(0)};
    end
  end

  assign ram_re    = cmd.rd_item || cmd.swp_rd;
  assign ram_raddr = cmd.swp_rd ? cnt : in_idx;

  fwrl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register; it holds until the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.req_commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_commit) begin
      if (item_limited) begin
        result_payload.accepted          <= under_limit;
        result_payload.request_count     <= RESULT_W'(cnt_new);
        result_payload.default_installed <= !rd_valid;
      end else begin
        result_payload.accepted          <= 1'b1;
        result_payload.request_count     <= '0;
        result_payload.default_installed <= 1'b0;
      end
    end
  end

endmodule

// ----- design/fixed_window_rate_limiter.sv -----
// Fixed-window rate limiter, top level. A request is a table read, then update and
// result; the update waits while the result register is full, and no new item is
// taken until it is done. A set is written in the cycle it is taken. A tick sweeps
// the table one entry a cycle. After reset a clearing pass invalidates every entry
// while no transaction is taken; configuration writes are taken throughout.
// Depends on fwrl_pkg, the channel interfaces, fwrl_ctrl and fwrl_datapath.
module fixed_window_rate_limiter #(
  parameter int USER_COUNT = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  fwrl_item_if.sink                        item,
  fwrl_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [fwrl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fwrl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fwrl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  assign item.ready = cmd.take;

  // Sequencing.
  fwrl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .st         (st),
    .cmd        (cmd)
  );

  // Table, defaults and result register.
  fwrl_datapath #(
    .USER_COUNT (USER_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_payload   (item.payload),
    .cmd            (cmd),
    .st             (st),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
  );

  // No transaction is taken in the cycle after reset: the clearing pass runs first.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !item.ready)
    else $error("input taken during the clearing pass");

  // A result is only loaded when the result register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.req_commit |-> !(result.valid && !result.ready))
    else $error("pending result overwritten");

  // At most one table operation is commanded in a cycle.
  a_one_table_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_wr, cmd.set_wr, cmd.req_commit, cmd.swp_rd, cmd.rd_item}))
    else $error("conflicting table operations");

  // The input stays closed in the cycle after the last sweep read, while that entry is written back.
  a_sweep_tail: assert property (@(posedge clk) disable iff (rst)
    (cmd.swp_rd && st.cnt_last) |=> !item.ready)
    else $error("input opened before the sweep finished");

endmodule

// ----- sim/fwrl_checker.sv -----
// Checker for the fixed-window rate limiter: watches both channels and the register port,
// keeps its own copy of the table and the defaults, and compares every verdict.
// Depends on fwrl_pkg and the two channel interfaces.
module fwrl_checker
  import fwrl_pkg::*;
#(
  parameter int USER_COUNT = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  fwrl_item_if                   item,
  fwrl_result_if                 result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int TABLE_DEPTH = CLASS_COUNT * USER_COUNT;
  localparam int MAX_REPORTS = 10;

  typedef logic [COUNT_BITS-1:0] count_t;

  // Shadow copy of the default registers.
  logic [LIMIT_W-1:0]   dflt_limit [CLASS_COUNT];
  logic [PERIODS_W-1:0] dflt_periods;

  // Shadow copy of the limiter table, one entry per (class, user) pair.
  bit                   ent_valid  [TABLE_DEPTH];
  logic [LIMIT_W-1:0]   ent_limit  [TABLE_DEPTH];
  logic [PERIOD_W-1:0]  ent_period [TABLE_DEPTH];
  count_t               ent_count  [TABLE_DEPTH];

  // Verdicts owed by the block, oldest first.
  result_t verdict_q [$];
  int      verdict_seq;

  // Apply one accepted command to the shadow table and queue any verdict it owes.
  function automatic void apply_command(input item_t it);
    int unsigned cls;
    int unsigned usr;
    int unsigned idx;
    int          i;
    bit          limited;
    bit          installed;
    count_t      cnt;
    result_t     verdict;
    cls     = it.op_class;
    usr     = it.user_id;
    limited = (cls < CLASS_COUNT) && (usr < USER_COUNT);
    idx     = cls * USER_COUNT + usr;
    case (cmd_code_t'(it.command))
      CMD_REQUEST: begin
        if (!limited) begin
          // Unlimited classes and unknown users always pass without touching the table.
          verdict.accepted          = 1'b1;
          verdict.request_count     = '0;
          verdict.default_installed = 1'b0;
        end else begin
          installed = !ent_valid[idx];
          if (installed) begin
            ent_valid[idx]  = 1'b1;
            ent_limit[idx]  = dflt_limit[cls];
            ent_period[idx] = dflt_periods[2*cls +: PERIOD_W];
            ent_count[idx]  = '0;
          end
          cnt = ent_count[idx];
          if (cnt != '1) cnt = cnt + 1'b1;
          ent_count[idx] = cnt;
          verdict.accepted          = (64'(cnt) <= 64'(ent_limit[idx]));
          verdict.request_count     = RESULT_W'(cnt);
          verdict.default_installed = installed;
        end
        verdict_q.push_back(verdict);
      end
      CMD_TICK: begin
        // A tick without a period clears nothing.
        if (|it.window_period) begin
          for (i = 0; i < TABLE_DEPTH; i++) begin
            if (ent_valid[i] && ent_period[i] == it.window_period) ent_count[i] = '0;
          end
        end
      end
      CMD_SET: begin
        if (limited) begin
          ent_valid[idx]  = 1'b1;
          ent_limit[idx]  = it.limit_value;
          ent_period[idx] = it.window_period;
          ent_count[idx]  = '0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Compare one verdict from the block with the oldest one owed.
  task automatic check_verdict(input result_t got);
    result_t want;
    if (verdict_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("mismatch: verdict %0d arrived with none owed (acc=%0b cnt=%0d inst=%0b)",
                 verdict_seq, got.accepted, got.request_count, got.default_installed);
    end else begin
      want = verdict_q.pop_front();
      if (got.accepted !== want.accepted || got.request_count !== want.request_count ||
          got.default_installed !== want.default_installed) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("mismatch: verdict %0d expected acc=%0b cnt=%0d inst=%0b, got acc=%0b cnt=%0d inst=%0b",
                   verdict_seq, want.accepted, want.request_count, want.default_installed,
                   got.accepted, got.request_count, got.default_installed);
      end
    end
    verdict_seq++;
  endtask

  // Follow the register port and both channels at every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CLASS_COUNT; c++) dflt_limit[c] = LIMIT_RESET;
      dflt_periods = PERIODS_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        ent_valid[i]  = 1'b0;
        ent_limit[i]  = '0;
        ent_period[i] = '0;
        ent_count[i]  = '0;
      end
      verdict_q.delete();
      verdict_seq = 0;
      fail_count  = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < CLASS_COUNT) dflt_limit[cfg_index] = cfg_data[LIMIT_W-1:0];
        else if (cfg_index == REG_PERIODS) dflt_periods = cfg_data[PERIODS_W-1:0];
      end
      // Retire the verdict before queueing a new one, so a stray verdict cannot match it.
      if (result.valid && result.ready) check_verdict(result.payload);
      if (item.valid && item.ready) apply_command(item.payload);
    end
    pending <= verdict_q.size();
  end

endmodule

// ----- sim/tb_fixed_window_rate_limiter.sv -----
// Testbench top for the fixed-window rate limiter: clock, reset, stimulus and verdict.
// Depends on fwrl_pkg, the channel interfaces, fwrl_checker and the block itself.
module tb_fixed_window_rate_limiter;
  import fwrl_pkg::*;

  localparam int USER_COUNT       = 256;
  localparam int COUNT_BITS       = 32;
  localparam int SWEEP_PAUSE      = CLASS_COUNT * USER_COUNT + 120;
  localparam int WATCHDOG_LIMIT   = 10000;
  localparam int RANDOM_PER_PHASE = 130;
  localparam int PHASE_COUNT      = 6;
  localparam int HEAVY_IDLE_PCT   = 73;
  localparam int LIGHT_IDLE_PCT   = 20;

  // Operation classes and the period codes that the package leaves out.
  localparam logic [CLASS_W-1:0]  CLASS_GET           = 3'd0;
  localparam logic [CLASS_W-1:0]  CLASS_PUT           = 3'd1;
  localparam logic [CLASS_W-1:0]  CLASS_DELETE        = 3'd2;
  localparam logic [CLASS_W-1:0]  CLASS_BUCKET_CREATE = 3'd3;
  localparam logic [CLASS_W-1:0]  CLASS_BUCKET_DELETE = 3'd4;
  localparam logic [CLASS_W-1:0]  CLASS_UNLIMITED     = 3'd5;
  localparam logic [CLASS_W-1:0]  CLASS_UNLIMITED_6   = 3'd6;
  localparam logic [CLASS_W-1:0]  CLASS_UNLIMITED_7   = 3'd7;
  localparam logic [PERIOD_W-1:0] PERIOD_NONE         = 2'd0;
  localparam logic [PERIOD_W-1:0] SECOND              = 2'd1;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     sender_idle_pct;
  int                     stall_pct;
  int                     fail_count;
  int                     pending;
  int                     quiet_cycles;

  fwrl_item_if   item_ch ();
  fwrl_result_if result_ch ();

  fixed_window_rate_limiter #(
    .USER_COUNT(USER_COUNT),
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  fwrl_checker #(
    .USER_COUNT(USER_COUNT),
    .COUNT_BITS(COUNT_BITS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Clock with a period of 20 units.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The receiver stalls at random, at the rate the current phase sets.
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t make_cmd(input cmd_code_t cmd, input logic [USER_W-1:0] usr,
                                     input logic [CLASS_W-1:0] cls,
                                     input logic [LIMIT_W-1:0] lim,
                                     input logic [PERIOD_W-1:0] per);
    item_t it;
    it.command       = cmd;
    it.user_id       = usr;
    it.op_class      = cls;
    it.limit_value   = lim;
    it.window_period = per;
    return it;
  endfunction

  // Mostly requests on a small group of users, so that counts climb past their limits.
  function automatic item_t random_cmd();
    item_t it;
    int    roll;
    roll = $urandom_range(99);
    if (roll < 75)      it.command = CMD_REQUEST;
    else if (roll < 87) it.command = CMD_SET;
    else if (roll < 95) it.command = CMD_TICK;
    else                it.command = CMD_RESERVED;
    it.user_id       = ($urandom_range(99) < 75) ? USER_W'($urandom_range(7)) : USER_W'($urandom);
    it.op_class      = ($urandom_range(99) < 85) ? CLASS_W'($urandom_range(4))
                                                 : CLASS_W'($urandom_range(7, 5));
    it.limit_value   = ($urandom_range(99) < 60) ? LIMIT_W'($urandom_range(5)) : $urandom;
    it.window_period = PERIOD_W'($urandom_range(3));
    return it;
  endfunction

  // Offer one command, idling first at random, and return at the edge that takes it.
  task automatic send_cmd(input item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.payload <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Wait until every verdict is in, then long enough for a tick sweep to finish.
  task automatic wait_drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SWEEP_PAUSE) @(posedge clk);
  endtask

  // Load the five default limits (class 0 in the low word) and the period register.
  task automatic program_defaults(input logic [CLASS_COUNT*LIMIT_W-1:0] limits,
                                  input logic [PERIODS_W-1:0] periods);
    int c;
    wait_drain();
    // The limit registers share their index with their class.
    for (c = 0; c < CLASS_COUNT; c++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(c);
      cfg_data  <= limits[c*LIMIT_W +: LIMIT_W];
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= REG_PERIODS;
    cfg_data  <= CFG_DATA_W'(periods);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.payload     = '0;
    result_ch.ready     = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    sender_idle_pct     = 0;
    stall_pct           = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed commands on the reset defaults, with no idling.
    send_cmd(make_cmd(CMD_REQUEST, 8'd0, CLASS_GET, '0, PERIOD_NONE));
    send_cmd(make_cmd(CMD_REQUEST, 8'd0, CLASS_GET, '1, HOUR));
    send_cmd(make_cmd(CMD_REQUEST, 8'd255, CLASS_PUT, '0, SECOND));
    send_cmd(make_cmd(CMD_REQUEST, 8'd128, CLASS_DELETE, '0, MINUTE));
    send_cmd(make_cmd(CMD_REQUEST, 8'd0, CLASS_BUCKET_CREATE, '0, PERIOD_NONE));
    send_cmd(make_cmd(CMD_REQUEST, 8'd255, CLASS_BUCKET_DELETE, '1, HOUR));
    // Unlimited classes pass straight through.
    send_cmd(make_cmd(CMD_REQUEST, 8'd7, CLASS_UNLIMITED, '0, PERIOD_NONE));
    send_cmd(make_cmd(CMD_REQUEST, 8'd255, CLASS_UNLIMITED_7, '1, HOUR));
    send_cmd(make_cmd(CMD_REQUEST, 8'd0, CLASS_UNLIMITED_6, '0, SECOND));
    // A minute tick reopens the window of the first entry.
    send_cmd(make_cmd(CMD_TICK, 8'd0, CLASS_GET, '0, MINUTE));
    send_cmd(make_cmd(CMD_REQUEST, 8'd0, CLASS_GET, '0, PERIOD_NONE));
    send_cmd(make_cmd(CMD_TICK, 8'd0, CLASS_GET, '0, PERIOD_NONE));
    send_cmd(make_cmd(CMD_TICK, 8'd255, CLASS_UNLIMITED_7, '1, SECOND));
    send_cmd(make_cmd(CMD_TICK, 8'd0, CLASS_GET, '0, HOUR));
    // A zero limit rejects at once; a second tick clears the count of an entry set to seconds.
    send_cmd(make_cmd(CMD_SET, 8'd1, CLASS_GET, '0, PERIOD_NONE));
    send_cmd(make_cmd(CMD_REQUEST, 8'd1, CLASS_GET, '0, PERIOD_NONE));
    send_cmd(make_cmd(CMD_SET, 8'd2, CLASS_PUT, '1, SECOND));
    send_cmd(make_cmd(CMD_REQUEST, 8'd2, CLASS_PUT, '0, PERIOD_NONE));
    send_cmd(make_cmd(CMD_TICK, 8'd0, CLASS_GET, '0, SECOND));
    send_cmd(make_cmd(CMD_REQUEST, 8'd2, CLASS_PUT, '0, PERIOD_NONE));
    // A set on an unlimited class and the reserved command are both ignored.
    send_cmd(make_cmd(CMD_SET, 8'd3, CLASS_UNLIMITED_6, 32'd4, SECOND));
    send_cmd(make_cmd(CMD_RESERVED, 8'd255, CLASS_UNLIMITED_7, '1, HOUR));
    // A set over a live entry reloads it with a zero count.
    send_cmd(make_cmd(CMD_SET, 8'd0, CLASS_GET, 32'd3, HOUR));
    send_cmd(make_cmd(CMD_REQUEST, 8'd0, CLASS_GET, '0, PERIOD_NONE));
    send_cmd(make_cmd(CMD_REQUEST, 8'd0, CLASS_GET, '0, PERIOD_NONE));

    // Random phases, each with its own defaults and with sender idling and receiver stalls set per phase.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: program_defaults('0, '0);
        1: program_defaults('1, '1);
        2: program_defaults({LIMIT_W'($urandom_range(4, 1)), LIMIT_W'($urandom_range(4, 1)),
                             LIMIT_W'($urandom_range(4, 1)), LIMIT_W'($urandom_range(4, 1)),
                             LIMIT_W'($urandom_range(4, 1))},
                            PERIODS_W'($urandom_range(1023)));
        3: program_defaults({32'd3, 32'd1, 32'd2, 32'd0, 32'hFFFF_FFFF},
                            {SECOND, SECOND, SECOND, SECOND, SECOND});
        4: program_defaults({$urandom, $urandom, $urandom, $urandom, $urandom},
                            PERIODS_W'($urandom_range(1023)));
        default: program_defaults({CLASS_COUNT{LIMIT_RESET}}, PERIODS_RESET);
      endcase
      case (phase)
        1: begin
          sender_idle_pct = HEAVY_IDLE_PCT;
          stall_pct       = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = HEAVY_IDLE_PCT;
        end
        3, 4: begin
          sender_idle_pct = LIGHT_IDLE_PCT;
          stall_pct       = LIGHT_IDLE_PCT;
        end
        default: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_cmd(random_cmd());
    end

    wait_drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
